>>> hdl/lsr_pkg.sv
// Shared widths, stream layout and controller/datapath interface types of the line rasterizer.
`default_nettype none

package lsr_pkg;

  // Coordinate, frame index and colour widths
  localparam int unsigned CoordW   = 7;
  localparam int unsigned IndexW   = 12;
  localparam int unsigned ColorW   = 8;
  localparam int unsigned StrideW  = 7;

  // Largest endpoint coordinate; larger ones are lowered to it
  localparam int unsigned MaxCoord = 64;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 56;

  typedef logic [CoordW-1:0] coord_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch a segment on an input transfer
    logic setup;    // derive axis, span and slope from the latched endpoints
    logic step;     // load one pixel into the output register and advance
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;  // output register empty or emptied this cycle
    logic at_end;    // the cursor sits on the last major coordinate
  } status_t;

endpackage

`default_nettype wire

>>> hdl/lsr_ctrl.sv
// Controller of the line rasterizer: idle, setup and run sequencing.
`default_nettype none

module lsr_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire lsr_pkg::status_t status_i,
  output lsr_pkg::cmd_t        cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StSetup = 2'd1;
  localparam logic [1:0] StRun   = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  // Issue commands and pick the next state
  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.setup   = 1'b0;
    cmd_o.step    = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StSetup;
        end
      end
      StSetup: begin
        cmd_o.setup = 1'b1;
        state_d     = StRun;
      end
      StRun: begin
        if (status_i.out_free) begin
          cmd_o.step = 1'b1;
          if (status_i.at_end) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/lsr_dp.sv
// Datapath of the line rasterizer: endpoint capture, stepping error term and output register.
`default_nettype none

module lsr_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire lsr_pkg::cmd_t                  cmd_i,
  output lsr_pkg::status_t                    status_o,
  input  wire logic [lsr_pkg::InDataW-1:0]    in_data_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [lsr_pkg::StrideW-1:0]    cfg_wdata_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [lsr_pkg::OutDataW-1:0]        out_data_o,
  output logic                                out_last_o
);

  localparam int unsigned CW = lsr_pkg::CoordW;
  localparam int unsigned ColW = 3 * lsr_pkg::ColorW;
  localparam int unsigned MaxCoord = lsr_pkg::MaxCoord;
  localparam int unsigned StrideReset = 64;

  // Raise a zero coordinate to one and lower an oversized one to the maximum
  function automatic lsr_pkg::coord_t clamp_coord(input lsr_pkg::coord_t v);
    lsr_pkg::coord_t c;
    c = v;
    if (c == '0) c = lsr_pkg::coord_t'(1);
    if (c > lsr_pkg::coord_t'(MaxCoord)) c = lsr_pkg::coord_t'(MaxCoord);
    return c;
  endfunction

  // Captured segment
  lsr_pkg::coord_t x1_q, y1_q, x2_q, y2_q;
  logic [ColW-1:0] colour_q;

  // Stepping state
  logic            ymaj_q;
  lsr_pkg::coord_t cur_q, hi_q, minor_q;
  logic signed [7:0] rem_q;
  logic signed [7:0] slope_q;
  logic [CW-1:0]   dist_q;

  logic [lsr_pkg::StrideW-1:0] stride_q;
  logic out_valid_q;
  logic [lsr_pkg::OutDataW-1:0] out_data_q;
  logic out_last_q;

  // Setup: pick the major axis and the span along it
  logic signed [7:0] dx, dy, abs_dx, abs_dy, d_major, d_minor, abs_major;
  logic              ymaj;
  lsr_pkg::coord_t   maj1, maj2, min1, min2;

  always_comb begin
    dx     = $signed({1'b0, x2_q}) - $signed({1'b0, x1_q});
    dy     = $signed({1'b0, y2_q}) - $signed({1'b0, y1_q});
    abs_dx = dx[7] ? -dx : dx;
    abs_dy = dy[7] ? -dy : dy;
    ymaj   = (x1_q == x2_q) || (abs_dy > abs_dx);
    maj1   = ymaj ? y1_q : x1_q;
    maj2   = ymaj ? y2_q : x2_q;
    min1   = ymaj ? x1_q : y1_q;
    min2   = ymaj ? x2_q : y2_q;
    d_major   = ymaj ? dy : dx;
    d_minor   = ymaj ? dx : dy;
    abs_major = ymaj ? abs_dy : abs_dx;
  end

  // Step: advance the remainder by the slope and fold it back into [0, span)
  logic signed [8:0] rsum, dsig;
  logic signed [8:0] rem_next;
  lsr_pkg::coord_t   minor_next;

  always_comb begin
    rsum = {rem_q[7], rem_q} + {slope_q[7], slope_q};
    dsig = $signed({2'b00, dist_q});
    if (rsum >= dsig) begin
      rem_next   = rsum - dsig;
      minor_next = minor_q + lsr_pkg::coord_t'(1);
    end else if (rsum < 0) begin
      rem_next   = rsum + dsig;
      minor_next = minor_q - lsr_pkg::coord_t'(1);
    end else begin
      rem_next   = rsum;
      minor_next = minor_q;
    end
  end

  // Pixel under the cursor and its frame index
  lsr_pkg::coord_t px, py, px_m1, py_m1;
  logic [2*CW-1:0] row_off;
  logic [lsr_pkg::IndexW-1:0] pix_index;

  always_comb begin
    px        = ymaj_q ? minor_q : cur_q;
    py        = ymaj_q ? cur_q : minor_q;
    px_m1     = px - lsr_pkg::coord_t'(1);
    py_m1     = py - lsr_pkg::coord_t'(1);
    row_off   = {{CW{1'b0}}, py_m1} * {{(2*CW-lsr_pkg::StrideW){1'b0}}, stride_q};
    pix_index = row_off[lsr_pkg::IndexW-1:0]
              + {{(lsr_pkg::IndexW-CW){1'b0}}, px_m1};
  end

  assign status_o.at_end   = (cur_q == hi_q);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Hold the stride and the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q    <= lsr_pkg::StrideW'(StrideReset);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        stride_q <= cfg_wdata_i;
      end
      if (cmd_i.step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture, set up and step the segment; load the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x1_q     <= clamp_coord(in_data_i[6:0]);
      y1_q     <= clamp_coord(in_data_i[13:7]);
      x2_q     <= clamp_coord(in_data_i[20:14]);
      y2_q     <= clamp_coord(in_data_i[27:21]);
      colour_q <= in_data_i[51:28];
    end
    if (cmd_i.setup) begin
      ymaj_q  <= ymaj;
      cur_q   <= (maj1 <= maj2) ? maj1 : maj2;
      hi_q    <= (maj1 <= maj2) ? maj2 : maj1;
      minor_q <= (maj1 <= maj2) ? min1 : min2;
      rem_q   <= '0;
      dist_q  <= abs_major[CW-1:0];
      slope_q <= d_major[7] ? -d_minor : d_minor;
    end
    if (cmd_i.step) begin
      out_data_q <= {6'b0, colour_q, pix_index, py, px};
      out_last_q <= status_o.at_end;
      if (!status_o.at_end) begin
        cur_q   <= cur_q + lsr_pkg::coord_t'(1);
        minor_q <= minor_next;
        rem_q   <= rem_next[7:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

>>> hdl/line_segment_rasterizer.sv
// Line rasterizer: one segment in, one pixel write per step out.
//
// s_axis carries a segment: both 1-based endpoints and a colour. Endpoints of 0
// are raised to 1 and those above 64 lowered to 64. m_axis carries one pixel
// write per step with tlast on the final pixel of the segment.
// A segment of N pixels (1..64): the transfer latches the endpoints, the setup
// state picks the major axis and slope, then the error term steps once per
// cycle; a stall on m_axis holds the output register and freezes the stepping.
// The first pixel reaches the output register after the setup state.
// The single stepping loop sets the rate: s_axis_tready_o is high only
// between segments, and the next segment may transfer while the last pixel of
// the previous one still waits on m_axis. row_stride is to be written through
// cfg_we_i/cfg_wdata_i between segments; the block does not enforce this.
// Reset empties the output register, returns to idle and sets row_stride to 64.
`default_nettype none

module line_segment_rasterizer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // start_x[6:0], start_y[13:7], end_x[20:14], end_y[27:21],
  // red[35:28], green[43:36], blue[51:44], zero[55:52]
  input  wire logic [55:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // pixel_x[6:0], pixel_y[13:7], pixel_index[25:14],
  // pixel_red[33:26], pixel_green[41:34], pixel_blue[49:42], zero[55:50]
  output logic [55:0]      m_axis_tdata_o,
  output logic             m_axis_tlast_o,   // last_pixel
  input  wire logic        cfg_we_i,
  input  wire logic [6:0]  cfg_wdata_i       // row_stride
);

  lsr_pkg::cmd_t    cmd;
  lsr_pkg::status_t status;

  lsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lsr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

>>> hdl/lsr_checker.sv
// Port-level checks of the line rasterizer and their binding to the top level.
`default_nettype none

module lsr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [55:0] m_axis_tdata_o,
  input wire logic        m_axis_tlast_o
);

  // No pixel is offered in the cycle after reset is seen
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("pixel offered during reset");

  // A stalled pixel holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled pixel changed");

  // A segment transfer is followed by the setup and run states, taking no new segment
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o ##1 !s_axis_tready_o)
    else $error("new segment taken during setup");

  // A pixel that is not the last one leaves only while the segment is in progress
  a_mid_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("segment accepted before the previous one finished");

endmodule

bind line_segment_rasterizer lsr_checker u_lsr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire
